// ===== rtl/kmnca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmnca_pkg
// Shared constants and types for the k-means nearest center assignment block.
// ----------------------------------------------------------------------------
package kmnca_pkg;

  localparam int MAX_CENTERS = 64;
  localparam int MAX_DIM     = 64;

  localparam int CIDX_W      = $clog2(MAX_CENTERS);
  localparam int STORE_DEPTH = MAX_CENTERS * MAX_DIM;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int TERM_W   = 2 * DIFF_W;
  localparam int DIST_W   = 40;
  localparam int COUNT_W  = 20;
  localparam int SUM_W    = 62;
  localparam int STAT_W   = COUNT_W + SUM_W;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_DISTANCE_MODE  = 1'b0;
  localparam logic CFG_CENTERS_IN_USE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_STAT_RD,
    ST_STAT_WR
  } state_t;

endpackage

// ===== rtl/kmnca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmnca_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmnca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kmeans_nearest_center_assign.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_nearest_center_assign
// k-means assignment step: per-element distance accumulation against all
// centers in use, nearest center search and saturating cluster statistics.
// ----------------------------------------------------------------------------
// Center loads and statistics clears never raise busy.
// A point element keeps busy high while the centers in use are processed:
// the center store is swept one center per cycle through its single read
// port, followed by a three-stage read / multiply / accumulate pipeline.
// An element marked last adds the statistics read-modify-write (ST_STAT_RD, ST_STAT_WR);
// its result word is strobed on result_valid in the first cycle with busy low.
// Results cannot be stalled. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module kmeans_nearest_center_assign (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic [5:0]                      center_sel,
  input  logic [5:0]                      element_index,
  input  logic signed [15:0]              sample_value,
  input  logic                            last_element,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [6:0]                      cfg_wdata,
  output logic                            result_valid,
  output logic [5:0]                      assigned_cluster,
  output logic [kmnca_pkg::DIST_W-1:0]    min_distance,
  output logic [kmnca_pkg::COUNT_W-1:0]   cluster_count,
  output logic [kmnca_pkg::SUM_W-1:0]     cluster_cost,
  output logic [kmnca_pkg::SUM_W-1:0]     total_objective
);

  import kmnca_pkg::*;

  state_t state, state_next;

  logic             distance_mode;
  logic [6:0]       centers_in_use;

  logic             accept;
  logic             issue;
  logic             drain_done;
  logic             stat_wr;

  logic [CIDX_W-1:0] issue_c;
  logic [CIDX_W-1:0] last_c;
  logic [CIDX_W-1:0] last_c_next;
  logic [5:0]        ei_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic              last_q;
  logic              in_range_q;

  logic              s1_vld;
  logic [CIDX_W-1:0] s1_c;
  logic              s2_vld;
  logic [CIDX_W-1:0] s2_c;
  logic [DIST_W-1:0] s2_old;
  logic [TERM_W-1:0] s2_term;

  logic [MAX_CENTERS-1:0] pv;
  logic [MAX_CENTERS-1:0] sv;

  logic [CIDX_W-1:0] best;
  logic [DIST_W-1:0] best_d;

  logic [SUM_W-1:0]  objective_sum;

  logic              load_we;
  logic [STORE_AW-1:0] load_addr;
  logic [STORE_AW-1:0] store_raddr;
  logic [SAMPLE_W-1:0] center_rdata;
  logic [DIST_W-1:0]   partial_rdata;
  logic [DIST_W-1:0]   partial_wdata;
  logic [STAT_W-1:0]   stat_rdata;
  logic [STAT_W-1:0]   stat_wdata;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [TERM_W-1:0]        term;
  logic [DIST_W:0]          acc_sum;

  logic [COUNT_W-1:0] cnt_old;
  logic [COUNT_W-1:0] cnt_new;
  logic [SUM_W-1:0]   cost_old;
  logic [SUM_W:0]     cost_sum;
  logic [SUM_W-1:0]   cost_new;
  logic [SUM_W:0]     obj_sum;
  logic [SUM_W-1:0]   obj_new;

  assign accept = start && !busy;

  // Control FSM
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_POINT) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (issue_c == last_c) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld && !s2_vld) begin
          state_next = last_q ? ST_STAT_RD : ST_IDLE;
        end
      end
      ST_STAT_RD: state_next = ST_STAT_WR;
      ST_STAT_WR: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    issue      = (state == ST_SWEEP);
    drain_done = (state == ST_DRAIN) && !s1_vld && !s2_vld;
    stat_wr    = (state == ST_STAT_WR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode  <= 1'b0;
      centers_in_use <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISTANCE_MODE:  distance_mode  <= cfg_wdata[0];
        CFG_CENTERS_IN_USE: centers_in_use <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (centers_in_use == 7'd0) begin
      last_c_next = '0;
    end else if (int'(centers_in_use) > MAX_CENTERS) begin
      last_c_next = CIDX_W'(MAX_CENTERS - 1);
    end else begin
      last_c_next = CIDX_W'(centers_in_use - 7'd1);
    end
  end

  // Center store
  assign load_we   = accept && opcode == OP_LOAD && int'(center_sel) < MAX_CENTERS &&
                     int'(element_index) < MAX_DIM;
  assign load_addr = STORE_AW'(STORE_AW'(center_sel) * STORE_AW'(MAX_DIM) +
                               STORE_AW'(element_index));
  assign store_raddr = STORE_AW'(STORE_AW'(issue_c) * STORE_AW'(MAX_DIM) + STORE_AW'(ei_q));

  kmnca_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_center_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (sample_value),
    .raddr (store_raddr),
    .rdata (center_rdata)
  );

  kmnca_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_CENTERS)
  ) u_partial (
    .clk   (clk),
    .we    (s2_vld),
    .waddr (s2_c),
    .wdata (partial_wdata),
    .raddr (issue_c),
    .rdata (partial_rdata)
  );

  kmnca_ram #(
    .WIDTH (STAT_W),
    .DEPTH (MAX_CENTERS)
  ) u_stats (
    .clk   (clk),
    .we    (stat_wr),
    .waddr (best),
    .wdata (stat_wdata),
    .raddr (best),
    .rdata (stat_rdata)
  );

  // Sweep datapath
  always_comb begin
    diff = $signed({sample_q[SAMPLE_W-1], sample_q}) -
           $signed({center_rdata[SAMPLE_W-1], center_rdata});
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    if (!in_range_q) begin
      term = '0;
    end else if (distance_mode) begin
      term = TERM_W'(mag);
    end else begin
      term = mag * mag;
    end
    acc_sum       = {1'b0, s2_old} + (DIST_W + 1)'(s2_term);
    partial_wdata = (acc_sum > (DIST_W + 1)'(DIST_MAX)) ? DIST_MAX : acc_sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_c <= '0;
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      pv      <= '0;
    end else begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
      if (accept) begin
        issue_c <= '0;
      end else if (issue) begin
        issue_c <= issue_c + 1'b1;
      end
      if (drain_done && last_q) begin
        pv <= '0;
      end else if (s2_vld) begin
        pv[s2_c] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_c     <= last_c_next;
      ei_q       <= element_index;
      sample_q   <= sample_value;
      last_q     <= last_element;
      in_range_q <= int'(element_index) < MAX_DIM;
    end
    s1_c    <= issue_c;
    s2_c    <= s1_c;
    s2_old  <= pv[s1_c] ? partial_rdata : '0;
    s2_term <= term;
    if (s2_vld && (s2_c == '0 || partial_wdata < best_d)) begin
      best   <= s2_c;
      best_d <= partial_wdata;
    end
  end

  // Statistics update
  always_comb begin
    cnt_old  = sv[best] ? stat_rdata[STAT_W-1:SUM_W] : '0;
    cost_old = sv[best] ? stat_rdata[SUM_W-1:0] : '0;
    cnt_new  = (cnt_old == COUNT_MAX) ? COUNT_MAX : cnt_old + 1'b1;
    cost_sum = {1'b0, cost_old} + (SUM_W + 1)'(best_d);
    cost_new = (cost_sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : cost_sum[SUM_W-1:0];
    obj_sum  = {1'b0, objective_sum} + (SUM_W + 1)'(best_d);
    obj_new  = (obj_sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : obj_sum[SUM_W-1:0];
    stat_wdata = {cnt_new, cost_new};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv            <= '0;
      objective_sum <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= stat_wr;
      if (accept && opcode == OP_CLEAR) begin
        sv            <= '0;
        objective_sum <= '0;
      end else if (stat_wr) begin
        sv[best]      <= 1'b1;
        objective_sum <= obj_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat_wr) begin
      assigned_cluster <= 6'(best);
      min_distance     <= best_d;
      cluster_count    <= cnt_new;
      cluster_cost     <= cost_new;
      total_objective  <= obj_new;
    end
  end

endmodule
